@@ sv/wpm_pkg.sv @@
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// Character codes, function and verdict codes, the broadcast bundle sent
// to every matcher cell, and the letter case folding helper.
// ----------------------------------------------------------------------------
package wpm_pkg;

    // pattern metacharacters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;

    // letter range for case folding
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // function codes of an input transaction
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_NAME = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // verdict codes of a result transaction
    localparam logic [1:0] VERDICT_MATCH    = 2'd0;
    localparam logic [1:0] VERDICT_EXCLUDED = 2'd1;
    localparam logic [1:0] VERDICT_NO_MATCH = 2'd2;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic       restart;    // use the start set instead of the stored bit
        logic       advance;    // a name character steps the chain
        logic       case_fold;  // compare letters ignoring case
        logic [7:0] name_char;  // folded name character
    } cell_bcast_t;

    // fold an upper case letter to lower case when folding is on
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic cf);
        logic [7:0] r;
        r = c;
        if (cf && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ sv/wpm_cell.sv @@
// ----------------------------------------------------------------------------
// wpm_cell: one pattern position of the matcher chain
// Holds one pattern character and the active bit of its position. On each
// name character it hands an advance or a star skip to its right neighbor.
// ----------------------------------------------------------------------------
module wpm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wpm_pkg::cell_bcast_t bc,
    input  logic [LEN_W-1:0]    len,
    input  logic                wr_en,
    input  logic [7:0]          wr_char,
    input  logic                init_bit,
    input  logic                adv_in,
    input  logic                skip_in,
    output logic                adv_out,
    output logic                skip_out,
    output logic                star_used,
    output logic                end_hit
);

    logic [7:0] char_reg;
    logic       act_reg;
    logic       used;
    logic       star;
    logic       act_eff;
    logic       match;
    logic       pre;
    logic       act_next;

    // classify the stored character
    assign used      = LEN_W'(IDX) < len;
    assign star      = used && (char_reg == wpm_pkg::CH_STAR);
    assign star_used = star;
    assign act_eff   = bc.restart ? init_bit : act_reg;
    assign match     = (char_reg == wpm_pkg::CH_QUEST) ||
                       (wpm_pkg::fold_char(char_reg, bc.case_fold) == bc.name_char);

    // step: a star stays, a literal or '?' advances, a star behind us is skipped
    assign pre      = (act_eff && star) || adv_in;
    assign act_next = pre || skip_in;
    assign adv_out  = act_eff && used && !star && match;
    assign skip_out = pre && star;

    // report the end position
    assign end_hit = act_eff && (LEN_W'(IDX) == len);

    // store the pattern character
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_reg <= wr_char;
        end
    end

    // advance the active bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (bc.advance)
        begin
            act_reg <= act_next;
        end
    end

endmodule

@@ sv/wildcard_pattern_match.sv @@
// ----------------------------------------------------------------------------
// wildcard_pattern_match: glob filter matcher over a chain of position cells
// Loads a pattern one character at a time and matches streamed file names
// against it with '*' and '?' wildcards and an optional inverse mark.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_stall  | func, data_char, begin_req
//  result  | out_valid / out_stall| verdict, pattern_overflow
//  config  | cfg_valid / cfg_ready| cfg_data (case_fold)
//
//  One input transaction per cycle while in_stall is low; a name character
//  updates every cell of the chain in that cycle, and an end of name puts its
//  result in the output register or the skid entry. A two-entry output buffer
//  keeps input flowing while the result side stalls; in_stall rises only when
//  both entries are full. Runs of '*' are stored as one, so the closure is one
//  neighbor hop. Reset clears the pattern length and start set at once.
// ----------------------------------------------------------------------------
module wildcard_pattern_match #(
    parameter int PATTERN_CAP = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] data_char,
    input  logic       begin_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    output logic       pattern_overflow,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_CAP + 1);

    logic [LEN_W-1:0] raw_len_reg, raw_len_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             inv_reg, inv_next;
    logic             ovf_reg, ovf_next;
    logic             last_star_reg, last_star_next;
    logic             fresh_reg, fresh_next;
    logic             act_last_reg;
    logic             case_fold_reg;

    logic             in_acc;
    logic             is_load;
    logic             is_name;
    logic             is_end;
    logic             store_en;
    logic             act_last_next;
    logic             hit;
    logic [1:0]       new_verdict;

    wpm_pkg::cell_bcast_t bc;

    logic [PATTERN_CAP-1:0] adv;
    logic [PATTERN_CAP-1:0] skip;
    logic [PATTERN_CAP-1:0] star_used;
    logic [PATTERN_CAP-1:0] end_hit;

    // output buffer: main register and skid entry
    logic       main_valid_reg, main_valid_next;
    logic [1:0] main_verdict_reg, main_verdict_next;
    logic       main_ovf_reg, main_ovf_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [1:0] skid_verdict_reg, skid_verdict_next;
    logic       skid_ovf_reg, skid_ovf_next;
    logic       push;
    logic       pop;

    // decode the input transaction
    assign in_acc  = in_valid && !in_stall;
    assign is_load = in_acc && (func == wpm_pkg::FUNC_LOAD);
    assign is_name = in_acc && (func == wpm_pkg::FUNC_NAME);
    assign is_end  = in_acc && (func == wpm_pkg::FUNC_END);

    // broadcast to the cells
    assign bc.restart   = fresh_reg || ((is_name || is_end) && begin_req);
    assign bc.advance   = is_name;
    assign bc.case_fold = case_fold_reg;
    assign bc.name_char = wpm_pkg::fold_char(data_char, case_fold_reg);

    // build the chain
    for (genvar i = 0; i < PATTERN_CAP; i++)
    begin : g_cell
        logic init_bit;
        logic adv_in;
        logic skip_in;

        if (i == 0)
        begin : g_first
            assign init_bit = 1'b1;
            assign adv_in   = 1'b0;
            assign skip_in  = 1'b0;
        end
        else
        begin : g_rest
            if (i == 1)
            begin : g_second
                assign init_bit = star_used[0];
            end
            else
            begin : g_other
                assign init_bit = 1'b0;
            end
            assign adv_in  = adv[i-1];
            assign skip_in = skip[i-1];
        end

        wpm_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bc        (bc),
            .len       (len_reg),
            .wr_en     (store_en && (len_next == LEN_W'(i + 1))),
            .wr_char   (data_char),
            .init_bit  (init_bit),
            .adv_in    (adv_in),
            .skip_in   (skip_in),
            .adv_out   (adv[i]),
            .skip_out  (skip[i]),
            .star_used (star_used[i]),
            .end_hit   (end_hit[i])
        );
    end

    // final position past the last cell
    assign act_last_next = adv[PATTERN_CAP-1] || skip[PATTERN_CAP-1];

    // evaluate the end of name
    assign hit = (|end_hit) ||
                 (!bc.restart && act_last_reg && (len_reg == LEN_W'(PATTERN_CAP)));
    assign new_verdict = hit ? (inv_reg ? wpm_pkg::VERDICT_EXCLUDED : wpm_pkg::VERDICT_MATCH)
                             : wpm_pkg::VERDICT_NO_MATCH;

    // load a pattern character
    always_comb
    begin
        logic [LEN_W-1:0] raw_e;
        logic [LEN_W-1:0] len_e;
        logic             inv_e;
        logic             ovf_e;
        logic             ls_e;

        raw_e = begin_req ? '0 : raw_len_reg;
        len_e = begin_req ? '0 : len_reg;
        inv_e = begin_req ? 1'b0 : inv_reg;
        ovf_e = begin_req ? 1'b0 : ovf_reg;
        ls_e  = begin_req ? 1'b0 : last_star_reg;

        raw_len_next   = raw_len_reg;
        len_next       = len_reg;
        inv_next       = inv_reg;
        ovf_next       = ovf_reg;
        last_star_next = last_star_reg;
        store_en       = 1'b0;
        fresh_next     = fresh_reg;

        if (is_load)
        begin
            raw_len_next   = raw_e;
            len_next       = len_e;
            inv_next       = inv_e;
            ovf_next       = ovf_e;
            last_star_next = ls_e;
            fresh_next     = 1'b1;
            if ((raw_e == '0) && !inv_e && !ovf_e && (data_char == wpm_pkg::CH_BANG))
            begin
                inv_next = 1'b1;
            end
            else if (raw_e < LEN_W'(PATTERN_CAP))
            begin
                raw_len_next = raw_e + 1'b1;
                // drop a star that follows a stored star
                if (!(ls_e && (data_char == wpm_pkg::CH_STAR)))
                begin
                    len_next       = len_e + 1'b1;
                    last_star_next = (data_char == wpm_pkg::CH_STAR);
                    store_en       = 1'b1;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (is_name)
        begin
            fresh_next = 1'b0;
        end
        else if (is_end)
        begin
            fresh_next = 1'b1;
        end
    end

    // hold pattern and match state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_len_reg   <= '0;
            len_reg       <= '0;
            inv_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            last_star_reg <= 1'b0;
            fresh_reg     <= 1'b1;
            act_last_reg  <= 1'b0;
            case_fold_reg <= 1'b0;
        end
        else
        begin
            raw_len_reg   <= raw_len_next;
            len_reg       <= len_next;
            inv_reg       <= inv_next;
            ovf_reg       <= ovf_next;
            last_star_reg <= last_star_next;
            fresh_reg     <= fresh_next;
            if (is_name)
            begin
                act_last_reg <= act_last_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case_fold_reg <= cfg_data;
            end
        end
    end

    // queue the result transaction
    assign push = is_end;
    assign pop  = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next   = main_valid_reg;
        main_verdict_next = main_verdict_reg;
        main_ovf_next     = main_ovf_reg;
        skid_valid_next   = skid_valid_reg;
        skid_verdict_next = skid_verdict_reg;
        skid_ovf_next     = skid_ovf_reg;

        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next   = 1'b1;
                main_verdict_next = skid_verdict_reg;
                main_ovf_next     = skid_ovf_reg;
                skid_valid_next   = 1'b0;
            end
            else
            begin
                main_valid_next   = push;
                main_verdict_next = new_verdict;
                main_ovf_next     = ovf_reg;
            end
        end
        else if (push)
        begin
            skid_valid_next   = 1'b1;
            skid_verdict_next = new_verdict;
            skid_ovf_next     = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_verdict_reg <= main_verdict_next;
        main_ovf_reg     <= main_ovf_next;
        skid_verdict_reg <= skid_verdict_next;
        skid_ovf_reg     <= skid_ovf_next;
    end

    // drive the ports
    assign in_stall         = skid_valid_reg;
    assign out_valid        = main_valid_reg;
    assign verdict          = main_verdict_reg;
    assign pattern_overflow = main_ovf_reg;
    assign cfg_ready        = 1'b1;

endmodule

@@ sv/wpm_checker.sv @@
// ----------------------------------------------------------------------------
// wpm_checker: port level checks for the wildcard pattern matcher
// Watches the handshakes and result codes at the top level ports.
// ----------------------------------------------------------------------------
module wpm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] func,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] verdict,
    input logic       pattern_overflow
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(pattern_overflow))
        else $error("stalled result transaction changed");

    // stall input only after the result side stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without a stalled result");

    // an accepted end of name yields a result next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == wpm_pkg::FUNC_END) |=> out_valid)
        else $error("end of name gave no result");

    // no result appears from nowhere
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && (func == wpm_pkg::FUNC_END)))
        else $error("result without an end of name");

    // keep verdict codes legal
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == wpm_pkg::VERDICT_MATCH) ||
                      (verdict == wpm_pkg::VERDICT_EXCLUDED) ||
                      (verdict == wpm_pkg::VERDICT_NO_MATCH))
        else $error("illegal verdict code");

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .verdict          (verdict),
    .pattern_overflow (pattern_overflow)
);
